// ===== hw/rtl/srit_pkg.sv =====
// ============================================================================
// Sorted record insert table package
// Sizes, record type, controller states and status codes shared by the table
// controller and the record store.
// ============================================================================
`default_nettype none

package srit_pkg;

    localparam int DEPTH    = 32;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int KEY_W    = 31;
    localparam int BAL_W    = 32;
    localparam int TAG_W    = 16;

    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [BAL_W-1:0] bal;
        logic [TAG_W-1:0]        tag;
    } t_record;

    typedef struct packed {
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        t_record       wr_data;
        logic          rd_en;
        logic [AW-1:0] rd_addr;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_RECORD   = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DUMP   = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_record_insert_table.sv =====
// ============================================================================
// Sorted record insert table
// Keeps up to DEPTH records in ascending account order; insert and dump.
// ============================================================================
// Usage:
//   A command transfers at a rising edge with start high and busy low. func
//   selects insert or dump. busy stays high while the sequencer works.
//   Each result is held on the o_ ports for one cycle with o_valid high;
//   the receiver cannot stall, every strobed result is taken.
//   Insert: the sequencer walks down from the top stored entry, one shared
//   compare per step; each step is a memory read then a compare and a write
//   of one entry one place up. The walk stops where the new record lands,
//   and the status follows the write of the new record; for an empty or full
//   table the status comes in the cycle after the transfer, and the full
//   table drops the record.
//   Dump: each record is read from memory and then shown, the last one
//   marked by o_last; an empty table answers with one empty status in the
//   next cycle.
//   A new command is taken in the cycle its last result is shown.
//   Reset (i_rst_n low, synchronous) empties the table and drops any
//   command in progress; the record memory itself is not cleared.
// ============================================================================
`default_nettype none

module sorted_record_insert_table (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic                              i_func,
    input  wire logic [srit_pkg::KEY_W-1:0]        i_account_number,
    input  wire logic signed [srit_pkg::BAL_W-1:0] i_balance_in,
    input  wire logic [srit_pkg::TAG_W-1:0]        i_name_tag,
    output      logic                              o_valid,
    output      logic [1:0]                        o_status,
    output      logic [srit_pkg::KEY_W-1:0]        o_account_out,
    output      logic signed [srit_pkg::BAL_W-1:0] o_balance_out,
    output      logic [srit_pkg::TAG_W-1:0]        o_tag_out,
    output      logic                              o_last
);

    srit_pkg::t_state              r_state, n_state;
    logic [srit_pkg::CW-1:0]       r_count, n_count;
    logic [srit_pkg::CW-1:0]       r_idx, n_idx;
    srit_pkg::t_record             r_new, n_new;

    logic                          r_valid, n_valid;
    srit_pkg::t_status             r_status, n_status;
    srit_pkg::t_record             r_out, n_out;
    logic                          r_last, n_last;

    srit_pkg::t_mem_req            w_req;
    srit_pkg::t_record             w_rd_data;
    logic                          w_accept;
    logic                          w_key_gt;
    logic                          w_dump_last;
    logic [srit_pkg::CW-1:0]       w_idx_m1;
    logic [srit_pkg::CW-1:0]       w_idx_p1;

    srit_store u_store (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

    assign busy        = (r_state != srit_pkg::S_IDLE);
    assign w_accept    = start && !busy;
    assign w_key_gt    = (r_new.key > w_rd_data.key);
    assign w_idx_m1    = r_idx - 1'b1;
    assign w_idx_p1    = r_idx + 1'b1;
    assign w_dump_last = (w_idx_p1 == r_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srit_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_func == srit_pkg::FUNC_INSERT) begin
                        if (r_count != srit_pkg::CNT_FULL && r_count != '0) begin
                            n_state = srit_pkg::S_INS_RD;
                        end
                    end else if (r_count != '0) begin
                        n_state = srit_pkg::S_DUMP_RD;
                    end
                end
            end
            srit_pkg::S_INS_RD: n_state = srit_pkg::S_INS_CMP;
            srit_pkg::S_INS_CMP: begin
                if (w_key_gt) begin
                    n_state = srit_pkg::S_IDLE;
                end else if (r_idx == srit_pkg::CW'(1)) begin
                    n_state = srit_pkg::S_INS_PUT;
                end else begin
                    n_state = srit_pkg::S_INS_RD;
                end
            end
            srit_pkg::S_INS_PUT: n_state = srit_pkg::S_IDLE;
            srit_pkg::S_DUMP_RD: n_state = srit_pkg::S_DUMP_OUT;
            srit_pkg::S_DUMP_OUT: begin
                n_state = w_dump_last ? srit_pkg::S_IDLE : srit_pkg::S_DUMP_RD;
            end
            default: n_state = srit_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count        = r_count;
        n_idx          = r_idx;
        n_new          = r_new;
        n_valid        = 1'b0;
        n_status       = srit_pkg::ST_INSERTED;
        n_out          = '0;
        n_last         = 1'b0;
        w_req.wr_en    = 1'b0;
        w_req.wr_addr  = r_idx[srit_pkg::AW-1:0];
        w_req.wr_data  = r_new;
        w_req.rd_en    = 1'b0;
        w_req.rd_addr  = r_idx[srit_pkg::AW-1:0];
        case (r_state)
            srit_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_new.key = i_account_number;
                    n_new.bal = i_balance_in;
                    n_new.tag = i_name_tag;
                    n_idx     = (i_func == srit_pkg::FUNC_INSERT) ? r_count : '0;
                    if (i_func == srit_pkg::FUNC_INSERT) begin
                        if (r_count == srit_pkg::CNT_FULL) begin
                            n_valid  = 1'b1;
                            n_status = srit_pkg::ST_FULL;
                            n_last   = 1'b1;
                        end else if (r_count == '0) begin
                            w_req.wr_en   = 1'b1;
                            w_req.wr_addr = '0;
                            w_req.wr_data = n_new;
                            n_count       = r_count + 1'b1;
                            n_valid       = 1'b1;
                            n_status      = srit_pkg::ST_INSERTED;
                            n_last        = 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_valid  = 1'b1;
                        n_status = srit_pkg::ST_EMPTY;
                        n_last   = 1'b1;
                    end
                end
            end
            srit_pkg::S_INS_RD: begin
                w_req.rd_en   = 1'b1;
                w_req.rd_addr = w_idx_m1[srit_pkg::AW-1:0];
            end
            srit_pkg::S_INS_CMP: begin
                w_req.wr_en = 1'b1;
                if (w_key_gt) begin
                    w_req.wr_data = r_new;
                    n_count       = r_count + 1'b1;
                    n_valid       = 1'b1;
                    n_status      = srit_pkg::ST_INSERTED;
                    n_last        = 1'b1;
                end else begin
                    w_req.wr_data = w_rd_data;
                    n_idx         = w_idx_m1;
                end
            end
            srit_pkg::S_INS_PUT: begin
                w_req.wr_en   = 1'b1;
                w_req.wr_data = r_new;
                n_count       = r_count + 1'b1;
                n_valid       = 1'b1;
                n_status      = srit_pkg::ST_INSERTED;
                n_last        = 1'b1;
            end
            srit_pkg::S_DUMP_RD: begin
                w_req.rd_en = 1'b1;
            end
            srit_pkg::S_DUMP_OUT: begin
                n_valid  = 1'b1;
                n_status = srit_pkg::ST_RECORD;
                n_out    = w_rd_data;
                n_last   = w_dump_last;
                n_idx    = w_idx_p1;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srit_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_idx    <= n_idx;
        r_new    <= n_new;
        r_status <= n_status;
        r_out    <= n_out;
        r_last   <= n_last;
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_account_out = r_out.key;
    assign o_balance_out = r_out.bal;
    assign o_tag_out     = r_out.tag;
    assign o_last        = r_last;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= srit_pkg::CNT_FULL)
        else $error("record count above table depth");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == srit_pkg::FUNC_INSERT && r_count == srit_pkg::CNT_FULL)
        |=> (o_valid && o_status == srit_pkg::ST_FULL && $stable(r_count)))
        else $error("insert into full table not dropped");

    a_empty_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == srit_pkg::FUNC_DUMP && r_count == '0)
        |=> (o_valid && o_status == srit_pkg::ST_EMPTY && o_last && !busy))
        else $error("empty dump not answered");

    a_shift_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srit_pkg::S_INS_RD || r_state == srit_pkg::S_INS_CMP)
        |-> (r_idx != '0 && r_idx <= r_count))
        else $error("shift index out of range");

    a_dump_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srit_pkg::S_DUMP_RD || r_state == srit_pkg::S_DUMP_OUT)
        |-> (r_idx < r_count))
        else $error("dump index past stored records");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/srit_store.sv =====
// ============================================================================
// Sorted record insert table record store
// Single write port, single read port record memory with registered read.
// ============================================================================
`default_nettype none

module srit_store (
    input  wire                logic     i_clk,
    input  wire srit_pkg::t_mem_req      i_req,
    output      srit_pkg::t_record       o_rd_data
);

    srit_pkg::t_record r_mem [srit_pkg::DEPTH];
    srit_pkg::t_record r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== bench/sorted_table_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Sorted record table checker
// Watches command transfers and result strobes of the sorted record table,
// keeps its own ordered copy of the records, and compares every strobed
// result against the oldest predicted one. Reports the failure count, the
// number of results still awaited, and a few totals for the run summary.
// ============================================================================

module sorted_table_checker
    import srit_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic                     i_busy,
    input  wire logic                     i_func,
    input  wire logic [KEY_W-1:0]         i_account_number,
    input  wire logic signed [BAL_W-1:0]  i_balance_in,
    input  wire logic [TAG_W-1:0]         i_name_tag,
    input  wire logic                     i_valid,
    input  wire logic [1:0]               i_status,
    input  wire logic [KEY_W-1:0]         i_account_out,
    input  wire logic signed [BAL_W-1:0]  i_balance_out,
    input  wire logic [TAG_W-1:0]         i_tag_out,
    input  wire logic                     i_last,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count,
    output int                            o_drop_count
);

    typedef struct packed {
        t_status                 status;
        logic [KEY_W-1:0]        key;
        logic signed [BAL_W-1:0] bal;
        logic [TAG_W-1:0]        tag;
        logic                    last;
    } t_answer;

    t_record rows [DEPTH];
    int      fill;
    t_answer answer_q [$];
    int      fail_total;
    int      result_total;
    int      drop_total;

    task automatic push_answer(input t_status st, input t_record rec, input logic lst);
        answer_q.push_back('{status: st, key: rec.key, bal: rec.bal, tag: rec.tag,
                             last: lst});
    endtask

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        t_record rec;
        int      pos;

        if (!i_rst_n) begin
            fill = 0;
            answer_q.delete();
            fail_total   = 0;
            result_total = 0;
            drop_total   = 0;
        end else begin
            // results leave before the command taken at the same edge
            if (i_valid) begin
                got = '{status: t_status'(i_status), key: i_account_out,
                        bal: i_balance_out, tag: i_tag_out, last: i_last};
                result_total++;
                if (answer_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("[%0t] unexpected st=%0d key=%h bal=%0d tag=%h last=%b",
                                 $realtime, got.status, got.key, got.bal, got.tag,
                                 got.last);
                end else begin
                    want = answer_q.pop_front();
                    if (got !== want) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("[%0t] expected st=%0d key=%h bal=%0d tag=%h last=%b",
                                     $realtime, want.status, want.key, want.bal,
                                     want.tag, want.last);
                            $display("[%0t]      got st=%0d key=%h bal=%0d tag=%h last=%b",
                                     $realtime, got.status, got.key, got.bal,
                                     got.tag, got.last);
                        end
                    end
                end
            end

            if (i_start && !i_busy) begin
                rec = '{key: i_account_number, bal: i_balance_in, tag: i_name_tag};
                if (i_func == FUNC_INSERT) begin
                    if (fill >= DEPTH) begin
                        push_answer(ST_FULL, '0, 1'b1);
                        drop_total++;
                    end else begin
                        pos = 0;
                        while (pos < fill && rec.key > rows[pos].key)
                            pos++;
                        for (int i = fill; i > pos; i--)
                            rows[i] = rows[i-1];
                        rows[pos] = rec;
                        fill++;
                        push_answer(ST_INSERTED, '0, 1'b1);
                    end
                end else if (fill == 0) begin
                    push_answer(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < fill; i++)
                        push_answer(ST_RECORD, rows[i], i == fill - 1);
                end
            end
        end

        o_fail_count   <= fail_total;
        o_pending      <= answer_q.size();
        o_result_count <= result_total;
        o_drop_count   <= drop_total;
    end

endmodule

// ===== bench/tb_sorted_record_insert_table.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Sorted record table testbench
// Drives insert and dump commands: a directed set of key, balance and tag
// extremes with duplicate keys, then random commands that fill the table,
// hit the full-table drop and dump the full table, under varying sender gaps.
// ============================================================================

module tb_sorted_record_insert_table;
    import srit_pkg::*;

    localparam int RANDOM_ITEMS   = 120;
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                    i_clk            = 1'b0;
    logic                    i_rst_n          = 1'b0;
    logic                    start            = 1'b0;
    logic                    busy;
    logic                    i_func           = FUNC_INSERT;
    logic [KEY_W-1:0]        i_account_number = '0;
    logic signed [BAL_W-1:0] i_balance_in     = '0;
    logic [TAG_W-1:0]        i_name_tag       = '0;
    logic                    o_valid;
    logic [1:0]              o_status;
    logic [KEY_W-1:0]        o_account_out;
    logic signed [BAL_W-1:0] o_balance_out;
    logic [TAG_W-1:0]        o_tag_out;
    logic                    o_last;

    int fail_count;
    int pending;
    int result_count;
    int drop_count;
    int idle_pct;
    int insert_count;
    int dump_count;
    int stall_cycles = 0;

    always #10 i_clk = ~i_clk;

    sorted_record_insert_table u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_account_number (i_account_number),
        .i_balance_in     (i_balance_in),
        .i_name_tag       (i_name_tag),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_account_out    (o_account_out),
        .o_balance_out    (o_balance_out),
        .o_tag_out        (o_tag_out),
        .o_last           (o_last)
    );

    sorted_table_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_func           (i_func),
        .i_account_number (i_account_number),
        .i_balance_in     (i_balance_in),
        .i_name_tag       (i_name_tag),
        .i_valid          (o_valid),
        .i_status         (o_status),
        .i_account_out    (o_account_out),
        .i_balance_out    (o_balance_out),
        .i_tag_out        (o_tag_out),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_result_count   (result_count),
        .o_drop_count     (drop_count)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_cmd(input logic func, input logic [KEY_W-1:0] key,
                            input logic signed [BAL_W-1:0] bal,
                            input logic [TAG_W-1:0] tag);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            // half the gaps begin only once the table is free again
            if ($urandom_range(0, 1) == 0)
                while (busy) @(posedge i_clk);
            while ($urandom_range(0, 99) < idle_pct) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_func           <= func;
        i_account_number <= key;
        i_balance_in     <= bal;
        i_name_tag       <= tag;
        do @(posedge i_clk); while (busy);
        if (func == FUNC_INSERT)
            insert_count++;
        else
            dump_count++;
    endtask

    task automatic wait_results_done();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [KEY_W-1:0]        key_pool [8];
        logic [KEY_W-1:0]        key_max;
        logic signed [BAL_W-1:0] bal_min;
        logic signed [BAL_W-1:0] bal_max;
        logic [31:0]             r;
        logic [KEY_W-1:0]        key;
        logic signed [BAL_W-1:0] bal;
        logic                    func;
        int                      sel;

        key_max      = '1;
        bal_min      = {1'b1, {(BAL_W-1){1'b0}}};
        bal_max      = {1'b0, {(BAL_W-1){1'b1}}};
        insert_count = 0;
        dump_count   = 0;
        idle_pct     = 0;
        key_pool[0]  = '0;
        key_pool[1]  = KEY_W'(1);
        key_pool[2]  = key_max;
        key_pool[3]  = key_max - 1'b1;
        for (int i = 4; i < 8; i++) begin
            r = $urandom();
            key_pool[i] = r[KEY_W-1:0];
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty dump, extremes, duplicate keys at both ends and middle
        send_cmd(FUNC_DUMP,   '0,             '0,      '0);
        send_cmd(FUNC_INSERT, KEY_W'(1000),   bal_max, 16'hFFFF);
        send_cmd(FUNC_INSERT, '0,             bal_min, 16'h0000);
        send_cmd(FUNC_INSERT, key_max,        '0,      16'h0001);
        send_cmd(FUNC_INSERT, KEY_W'(1000),   -1,      16'h0002);
        send_cmd(FUNC_INSERT, KEY_W'(1000),   1,       16'h0003);
        send_cmd(FUNC_INSERT, key_max,        bal_min, 16'h0004);
        send_cmd(FUNC_INSERT, '0,             bal_max, 16'h0005);
        send_cmd(FUNC_DUMP,   key_max,        bal_max, 16'hFFFF);
        send_cmd(FUNC_INSERT, KEY_W'(500),    -2,      16'hAAAA);
        send_cmd(FUNC_INSERT, KEY_W'(1001),   2,       16'h5555);
        send_cmd(FUNC_DUMP,   '0,             bal_min, 16'h0000);
        wait_results_done();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case (n * 4 / RANDOM_ITEMS)
                0:       idle_pct = 0;
                1:       idle_pct = 78;
                2:       idle_pct = 0;
                default: idle_pct = 35;
            endcase
            if (n == RANDOM_ITEMS / 2)
                wait_results_done();

            func = ($urandom_range(0, 99) < 30) ? FUNC_DUMP : FUNC_INSERT;
            sel  = $urandom_range(0, 9);
            r    = $urandom();
            if (sel < 4)
                key = key_pool[$urandom_range(0, 7)];
            else if (sel == 4)
                key = '0;
            else if (sel == 5)
                key = key_max;
            else
                key = r[KEY_W-1:0];
            case ($urandom_range(0, 7))
                0:       bal = bal_min;
                1:       bal = bal_max;
                default: bal = $urandom();
            endcase
            send_cmd(func, key, bal, TAG_W'($urandom_range(0, 16'hFFFF)));
        end

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d inserts and %0d dumps, %0d results checked.",
                 insert_count, dump_count, result_count);
        $display("Full-table drops seen: %0d; duplicate and extreme keys included.",
                 drop_count);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
